// ----- src/pgbs_pkg.sv -----
// Shared types, constants and register codes for the pedal gain binary search.
// Used by every module of the block; depends on nothing.
`default_nettype none
package pgbs_pkg;

  localparam int unsigned READING_W = 18;
  localparam int unsigned GAIN_W    = 7;
  localparam int unsigned TRIES_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [READING_W-1:0] READING_MAX        = 18'd262080;
  localparam logic [GAIN_W-1:0]    GAIN_START         = 7'd63;
  localparam logic [GAIN_W-1:0]    STEP_START         = 7'd64;
  localparam logic [READING_W-1:0] LOWER_BOUND_RESET  = 18'd0;
  localparam logic [READING_W-1:0] UPPER_BOUND_RESET  = 18'd262080;
  localparam logic [READING_W-1:0] THRESHOLD_RESET    = 18'd1310;
  localparam logic [TRIES_W-1:0]   MAX_TRIES_RESET    = 8'd20;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_SLOT  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER_BOUND = 2'd0,
    REG_UPPER_BOUND = 2'd1,
    REG_THRESHOLD   = 2'd2,
    REG_MAX_TRIES   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                 command;
    logic                 has_reading;
    logic [READING_W-1:0] reading;
  } item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              gain_changed;
    logic              finished;
    logic              found;
  } result_t;

  typedef struct packed {
    logic [READING_W-1:0] lower_bound;
    logic [READING_W-1:0] upper_bound;
    logic [READING_W-1:0] stability_threshold;
    logic [TRIES_W-1:0]   max_tries;
  } cfg_t;

endpackage
`default_nettype wire

// ----- src/pgbs_in_stage.sv -----
// Input register of the gain search: holds one accepted item until the
// search stage takes it. Depends on pgbs_pkg.
`default_nettype none
module pgbs_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pgbs_pkg::item_t in_item,
  output logic               held_valid,
  output pgbs_pkg::item_t    held_item,
  input  wire logic          take
);

  logic            valid;
  pgbs_pkg::item_t item;

  // The register frees up in the same cycle that its item moves on.
  assign in_ready   = !valid || take;
  assign held_valid = valid;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule
`default_nettype wire

// ----- src/pgbs_search.sv -----
// Search state of the gain binary search and the single-pass update that one
// item applies to it. Depends on pgbs_pkg.
`default_nettype none
module pgbs_search (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire pgbs_pkg::item_t item,
  input  wire pgbs_pkg::cfg_t  cfg,
  output pgbs_pkg::result_t    result
);

  logic [pgbs_pkg::GAIN_W-1:0]    gain_value, gain_value_next;
  logic [pgbs_pkg::GAIN_W-1:0]    gain_step, gain_step_next;
  logic [pgbs_pkg::TRIES_W-1:0]   tries_left, tries_left_next;
  logic [pgbs_pkg::READING_W-1:0] previous_reading, previous_reading_next;
  logic                           have_previous, have_previous_next;
  logic                           searching, searching_next;

  logic [pgbs_pkg::READING_W-1:0] clamped;
  logic [pgbs_pkg::READING_W-1:0] diff;
  logic [pgbs_pkg::TRIES_W-1:0]   tries_dec;
  logic [pgbs_pkg::GAIN_W-1:0]    step_half;
  logic [pgbs_pkg::READING_W:0]   twice;
  logic [pgbs_pkg::READING_W:0]   bound_sum;
  logic                           stable;
  logic                           changed, finished, found;

  always_comb begin
    clamped   = (item.reading > pgbs_pkg::READING_MAX) ? pgbs_pkg::READING_MAX : item.reading;
    diff      = (clamped >= previous_reading) ? (clamped - previous_reading)
                                              : (previous_reading - clamped);
    tries_dec = (tries_left != '0) ? (tries_left - 1'b1) : tries_left;
    step_half = gain_step >> 1;
    twice     = {clamped, 1'b0};
    bound_sum = {1'b0, cfg.lower_bound} + {1'b0, cfg.upper_bound};
    stable    = item.has_reading && have_previous && (diff <= cfg.stability_threshold);

    gain_value_next       = gain_value;
    gain_step_next        = gain_step;
    tries_left_next       = tries_left;
    previous_reading_next = previous_reading;
    have_previous_next    = have_previous;
    searching_next        = searching;
    changed               = 1'b0;
    finished              = 1'b0;
    found                 = 1'b0;

    if (item.command == pgbs_pkg::CMD_START) begin
      gain_value_next    = pgbs_pkg::GAIN_START;
      gain_step_next     = pgbs_pkg::STEP_START;
      searching_next     = 1'b1;
      tries_left_next    = cfg.max_tries;
      have_previous_next = 1'b0;
      changed            = 1'b1;
    end else if (searching) begin
      tries_left_next = tries_dec;
      if (item.has_reading) begin
        previous_reading_next = clamped;
        have_previous_next    = 1'b1;
      end
      if (stable) begin
        if (clamped > cfg.lower_bound && clamped < cfg.upper_bound) begin
          searching_next = 1'b0;
          finished       = 1'b1;
          found          = 1'b1;
        end else begin
          gain_step_next = step_half;
          if (step_half > 7'd1) begin
            // Reading above the midpoint of the bounds pushes the gain up.
            gain_value_next    = (twice > bound_sum) ? (gain_value + step_half)
                                                     : (gain_value - step_half);
            changed            = 1'b1;
            tries_left_next    = cfg.max_tries;
            have_previous_next = 1'b0;
          end else begin
            searching_next = 1'b0;
            finished       = 1'b1;
          end
        end
      end else if (tries_dec == '0) begin
        searching_next = 1'b0;
        finished       = 1'b1;
      end
    end

    result.gain         = gain_value_next;
    result.gain_changed = changed;
    result.finished     = finished;
    result.found        = found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_value       <= pgbs_pkg::GAIN_START;
      gain_step        <= pgbs_pkg::STEP_START;
      tries_left       <= '0;
      previous_reading <= '0;
      have_previous    <= 1'b0;
      searching        <= 1'b0;
    end else if (advance) begin
      gain_value       <= gain_value_next;
      gain_step        <= gain_step_next;
      tries_left       <= tries_left_next;
      previous_reading <= previous_reading_next;
      have_previous    <= have_previous_next;
      searching        <= searching_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/pgbs_out_stage.sv -----
// Result register of the gain search: holds one result item until the
// receiver takes it. Depends on pgbs_pkg.
`default_nettype none
module pgbs_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire pgbs_pkg::result_t load_result,
  output logic                   can_load,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pgbs_pkg::result_t      out_result
);

  logic              valid;
  pgbs_pkg::result_t result;

  assign can_load   = !valid || out_ready;
  assign out_valid  = valid;
  assign out_result = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      result <= load_result;
    end
  end

endmodule
`default_nettype wire

// ----- src/pedal_gain_binary_search.sv -----
// Top level of the pedal gain binary search: configuration registers and the
// input register, search stage and result register. Depends on pgbs_pkg.
//
// Usage:
// Items enter on the input channel (in_valid/in_ready with command,
// has_reading and reading) and results leave on the output channel
// (out_valid/out_ready with gain, gain_changed, finished and found).
// Every item gives exactly one result item. A start command restarts the
// search at gain 63; each reading slot then advances the stability check
// and, on a stable reading, either ends the search or moves the gain.
// An item is captured in the input register at acceptance, the search state
// is updated as it moves on into the result register, and its result is
// offered on the output from the result register. One item is taken in
// every cycle while the receiver keeps up; the search stage updates its
// state once per item as the item moves on.
// When the receiver stalls, the result register holds its item, the input
// register fills behind it, and in_ready then drops until the result moves.
// Reset empties both registers, restores the configuration reset values and
// returns the search to idle with gain 63.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
// clock edge and are meant for times when no item is in flight.
`default_nettype none
module pedal_gain_binary_search (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 command,
  input  wire logic                                 has_reading,
  input  wire logic [pgbs_pkg::READING_W-1:0]       reading,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [pgbs_pkg::GAIN_W-1:0]               gain,
  output logic                                      gain_changed,
  output logic                                      finished,
  output logic                                      found,
  input  wire logic                                 cfg_write,
  input  wire logic [pgbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pgbs_pkg::READING_W-1:0]       cfg_data
);

  pgbs_pkg::cfg_t    cfg;
  pgbs_pkg::item_t   in_item;
  pgbs_pkg::item_t   held_item;
  pgbs_pkg::result_t step_result;
  pgbs_pkg::result_t out_result;
  logic              held_valid;
  logic              can_load;
  logic              advance;

  // Configuration registers; the low bits of the data word feed the
  // narrower try count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lower_bound         <= pgbs_pkg::LOWER_BOUND_RESET;
      cfg.upper_bound         <= pgbs_pkg::UPPER_BOUND_RESET;
      cfg.stability_threshold <= pgbs_pkg::THRESHOLD_RESET;
      cfg.max_tries           <= pgbs_pkg::MAX_TRIES_RESET;
    end else if (cfg_write) begin
      case (pgbs_pkg::cfg_reg_t'(cfg_index))
        pgbs_pkg::REG_LOWER_BOUND: cfg.lower_bound         <= cfg_data;
        pgbs_pkg::REG_UPPER_BOUND: cfg.upper_bound         <= cfg_data;
        pgbs_pkg::REG_THRESHOLD:   cfg.stability_threshold <= cfg_data;
        pgbs_pkg::REG_MAX_TRIES:   cfg.max_tries <= cfg_data[pgbs_pkg::TRIES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_item.command     = command;
  assign in_item.has_reading = has_reading;
  assign in_item.reading     = reading;

  // The held item is processed exactly when the result register can take it.
  assign advance = held_valid && can_load;

  pgbs_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (advance)
  );

  pgbs_search u_search (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held_item),
    .cfg     (cfg),
    .result  (step_result)
  );

  pgbs_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .load        (held_valid),
    .load_result (step_result),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result  (out_result)
  );

  assign gain         = out_result.gain;
  assign gain_changed = out_result.gain_changed;
  assign finished     = out_result.finished;
  assign found        = out_result.found;

endmodule
`default_nettype wire
